// ===== hw/rtl/gcrg_pkg.sv =====
package gcrg_pkg;

	// Field widths of the channels and the configuration register.
	localparam int VERTEX_W = 5;
	localparam int NEIGH_W  = 32;
	localparam int COLOR_W  = 8;
	localparam int COUNT_W  = 6;

	// After reset, 32 vertices are in use.
	localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

	typedef logic [VERTEX_W-1:0] vertex_t;
	typedef logic [NEIGH_W-1:0]  neigh_t;
	typedef logic [COLOR_W-1:0]  color_t;
	typedef logic [COUNT_W-1:0]  count_t;

	// Input operation codes.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_RUN  = 1'b1
	} op_t;

endpackage

// ===== hw/rtl/gcrg_if.sv =====
// Input channel: one load or run item per transfer.
interface gcrg_in_if;
	import gcrg_pkg::*;

	logic    valid;
	logic    ready;
	op_t     operation;
	vertex_t vertex;
	neigh_t  neighbours;
	color_t  initial_color;

	modport source (
		output valid, operation, vertex, neighbours, initial_color,
		input  ready
	);
	modport sink (
		input  valid, operation, vertex, neighbours, initial_color,
		output ready
	);
endinterface

// Output channel: one vertex color per transfer.
interface gcrg_out_if;
	import gcrg_pkg::*;

	logic    valid;
	logic    ready;
	vertex_t out_vertex;
	color_t  final_color;
	logic    last;

	modport source (
		output valid, out_vertex, final_color, last,
		input  ready
	);
	modport sink (
		input  valid, out_vertex, final_color, last,
		output ready
	);
endinterface

// ===== hw/rtl/gcrg_ram.sv =====
// Simple dual-port memory: one write port, one read port, registered read data.
module gcrg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/gcrg_seq.sv =====
// Sequencer: takes loads into the memories, grows color regions over the
// worklist with read-modify-write passes, then streams out the colors.
module gcrg_seq #(
	parameter int MAX_VERTICES = 32,
	parameter int COLOR_BITS   = 8,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	gcrg_in_if.sink                 in_ch,
	gcrg_out_if.source              out_ch,
	input  logic [CW-1:0]           count,
	output logic                    adj_we,
	output logic [VW-1:0]           adj_waddr,
	output logic [MAX_VERTICES-1:0] adj_wdata,
	output logic [VW-1:0]           adj_raddr,
	input  logic [MAX_VERTICES-1:0] adj_rdata,
	output logic                    col_we,
	output logic [VW-1:0]           col_waddr,
	output logic [COLOR_BITS-1:0]   col_wdata,
	output logic [VW-1:0]           col_raddr,
	input  logic [COLOR_BITS-1:0]   col_rdata
);
	import gcrg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PICK,
		S_HEAD,
		S_SWEEP,
		S_CAND,
		S_CHECK,
		S_EMIT_LD,
		S_EMIT_HOLD
	} state_t;

	state_t                  state_q;
	logic [MAX_VERTICES-1:0] wl_q;
	logic [MAX_VERTICES-1:0] row_q;
	logic [MAX_VERTICES-1:0] ok_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           j_q;
	logic [VW-1:0]           v_q;
	logic [VW-1:0]           i_q;
	logic [VW-1:0]           k_q;
	logic [COLOR_BITS-1:0]   c_q;
	logic                    sw_v_s1;
	logic [VW-1:0]           sw_idx_s1;
	logic                    ov_q;
	logic [VW-1:0]           ovtx_q;
	logic [COLOR_BITS-1:0]   ocol_q;
	logic                    olast_q;

	logic [MAX_VERTICES-1:0] live_mask;
	logic [MAX_VERTICES-1:0] cand;
	logic [VW-1:0]           wl_pick;
	logic [VW-1:0]           cand_pick;
	logic                    in_acc;
	logic                    load_ok;
	logic                    take;

	// Bits below n set.
	function automatic logic [MAX_VERTICES-1:0] low_mask(input logic [CW-1:0] n);
		logic [MAX_VERTICES-1:0] m;
		m = '0;
		for (int b = 0; b < MAX_VERTICES; b++) begin
			m[b] = (b < int'(n));
		end
		return m;
	endfunction

	// Index of the lowest set bit, zero when none is set.
	function automatic logic [VW-1:0] first_set(input logic [MAX_VERTICES-1:0] m);
		logic [VW-1:0] idx;
		idx = '0;
		for (int b = MAX_VERTICES - 1; b >= 0; b--) begin
			if (m[b]) begin
				idx = VW'(b);
			end
		end
		return idx;
	endfunction

	// Selection and decode.
	assign live_mask = low_mask(n_q);
	assign cand      = row_q & live_mask;
	assign wl_pick   = first_set(wl_q);
	assign cand_pick = first_set(cand);
	assign in_acc    = in_ch.valid & in_ch.ready;
	assign load_ok   = in_acc && (in_ch.operation == OP_LOAD) &&
	                   (int'(in_ch.vertex) < MAX_VERTICES);
	// A candidate may take the color when none of its live neighbours holds
	// a different nonzero color.
	assign take      = ((adj_rdata & live_mask & ~ok_q) == '0);

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = ov_q;
	assign out_ch.out_vertex  = VERTEX_W'(ovtx_q);
	assign out_ch.final_color = COLOR_W'(ocol_q);
	assign out_ch.last        = olast_q;

	// Memory ports. Writes happen only in the idle and check states, reads in
	// the others, so no access to one entry overlaps another.
	always_comb begin
		adj_we    = load_ok;
		adj_waddr = VW'(in_ch.vertex);
		adj_wdata = MAX_VERTICES'(in_ch.neighbours);
		col_we    = load_ok || ((state_q == S_CHECK) && take);
		col_waddr = load_ok ? VW'(in_ch.vertex) : i_q;
		col_wdata = load_ok ? COLOR_BITS'(in_ch.initial_color) : c_q;

		case (state_q)
			S_CAND:  adj_raddr = cand_pick;
			default: adj_raddr = wl_pick;
		endcase

		case (state_q)
			S_SWEEP:     col_raddr = j_q[VW-1:0];
			S_EMIT_HOLD: col_raddr = k_q + VW'(1);
			default:     col_raddr = wl_pick;
		endcase
	end

	// State, worklist, sweep pipeline and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wl_q    <= '0;
			sw_v_s1 <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			// Sweep: one color read issued per cycle, checked in the next cycle.
			sw_v_s1   <= (state_q == S_SWEEP) && (j_q != n_q);
			sw_idx_s1 <= j_q[VW-1:0];
			if (sw_v_s1) begin
				ok_q[sw_idx_s1] <= (col_rdata == '0) || (col_rdata == c_q);
				if (col_rdata != '0) begin
					row_q[sw_idx_s1] <= 1'b0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_ch.operation == OP_RUN) && (count != '0)) begin
						n_q     <= count;
						wl_q    <= low_mask(count);
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (wl_q == '0) begin
						k_q     <= '0;
						state_q <= S_EMIT_LD;
					end else begin
						v_q     <= wl_pick;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (col_rdata == '0) begin
						wl_q[v_q] <= 1'b0;
						state_q   <= S_PICK;
					end else begin
						c_q     <= col_rdata;
						row_q   <= adj_rdata & live_mask;
						j_q     <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (j_q == n_q) begin
						state_q <= S_CAND;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_CAND: begin
					if (cand == '0) begin
						wl_q[v_q] <= 1'b0;
						state_q   <= S_PICK;
					end else begin
						i_q              <= cand_pick;
						row_q[cand_pick] <= 1'b0;
						state_q          <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (take) begin
						wl_q[i_q] <= 1'b1;
					end
					state_q <= S_CAND;
				end
				S_EMIT_LD: begin
					ov_q    <= 1'b1;
					ovtx_q  <= k_q;
					ocol_q  <= col_rdata;
					olast_q <= ((CW'(k_q) + CW'(1)) == n_q);
					state_q <= S_EMIT_HOLD;
				end
				S_EMIT_HOLD: begin
					if (out_ch.ready) begin
						ov_q <= 1'b0;
						if (olast_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + VW'(1);
							state_q <= S_EMIT_LD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The worklist is empty whenever a new item can be taken.
	a_idle_wl_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (wl_q == '0))
		else $error("worklist not empty while idle");

	// Candidates are only examined for a colored vertex.
	a_cand_colored: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CAND || state_q == S_CHECK) |-> (c_q != '0))
		else $error("candidate pass under an uncolored vertex");

	// Growth writes only the nonzero color of the current vertex.
	a_grow_write: assert property (@(posedge clk) disable iff (!arst_n)
		(col_we && state_q != S_IDLE) |-> (col_wdata == c_q && c_q != '0))
		else $error("bad color written during growth");

	// Sweep reads stay below the vertex count.
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sw_v_s1 |-> (CW'(sw_idx_s1) < n_q))
		else $error("sweep index out of range");

	// A result is offered only while the sequencer waits on the output.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (state_q == S_EMIT_HOLD))
		else $error("output valid outside the emit state");
endmodule

// ===== hw/rtl/greedy_color_region_growing.sv =====
// Channel  | Dir | Transfer carries
// ---------+-----+---------------------------------------------------------
// in_ch    | in  | operation, vertex, neighbours, initial_color
// out_ch   | out | out_vertex, final_color, last
// cfg      | in  | cfg_we with cfg_wdata writes vertex_count
//
// A load is written into the memories when it is taken. A run picks each
// vertex from the worklist: an uncolored one is dropped, and a colored one
// sweeps the colors of all vertices in use through the single color memory
// read port, then checks each uncolored neighbour; then each color is emitted.
// Reset clears control state only; the memories hold no reset contents and
// need no clearing pass. A stalled output holds the sequencer, and no new
// item is taken until the last color of a run is transferred.
module greedy_color_region_growing #(
	parameter int MAX_VERTICES = 32,
	parameter int COLOR_BITS   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	gcrg_in_if.sink           in_ch,
	gcrg_out_if.source        out_ch,
	input  logic              cfg_we,
	input  gcrg_pkg::count_t  cfg_wdata
);
	import gcrg_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	count_t                  vertex_count_q;
	logic [CW-1:0]           count;
	logic                    adj_we;
	logic [VW-1:0]           adj_waddr;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic [VW-1:0]           adj_raddr;
	logic [MAX_VERTICES-1:0] adj_rdata;
	logic                    col_we;
	logic [VW-1:0]           col_waddr;
	logic [COLOR_BITS-1:0]   col_wdata;
	logic [VW-1:0]           col_raddr;
	logic [COLOR_BITS-1:0]   col_rdata;

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// A count above the vertex capacity acts as the capacity.
	assign count = (32'(vertex_count_q) > MAX_VERTICES) ? CW'(MAX_VERTICES)
	                                                     : CW'(vertex_count_q);

	// Adjacency rows.
	gcrg_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_adj (
		.clk  (clk),
		.we   (adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	// Vertex colors.
	gcrg_ram #(
		.WIDTH(COLOR_BITS),
		.DEPTH(MAX_VERTICES)
	) u_col (
		.clk  (clk),
		.we   (col_we),
		.waddr(col_waddr),
		.wdata(col_wdata),
		.raddr(col_raddr),
		.rdata(col_rdata)
	);

	// Sequencer.
	gcrg_seq #(
		.MAX_VERTICES(MAX_VERTICES),
		.COLOR_BITS  (COLOR_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.count    (count),
		.adj_we   (adj_we),
		.adj_waddr(adj_waddr),
		.adj_wdata(adj_wdata),
		.adj_raddr(adj_raddr),
		.adj_rdata(adj_rdata),
		.col_we   (col_we),
		.col_waddr(col_waddr),
		.col_wdata(col_wdata),
		.col_raddr(col_raddr),
		.col_rdata(col_rdata)
	);
endmodule
